>>> design/bpfa_pkg.sv
// Package for the bitmap page frame allocator.
// Holds field widths, map geometry, request and status codes.
// No dependencies.
package bpfa_pkg;

  localparam int MAP_WORD_BITS   = 32;
  localparam int WORD_BIT_W      = $clog2(MAP_WORD_BITS);
  localparam int PAGE_BYTES      = 4096;
  localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);
  localparam int ADDR_W          = 32;
  localparam int FRAME_W         = 17;
  localparam int TOTAL_MAX       = (1 << FRAME_W) - 1;
  localparam int FRAME_LIMIT_DEF = 65536;
  localparam int TOTAL_RESET     = 65536;

  localparam logic [1:0] MODE_ALLOC      = 2'd0;
  localparam logic [1:0] MODE_FREE       = 2'd1;
  localparam logic [1:0] MODE_RANGE_FREE = 2'd2;
  localparam logic [1:0] MODE_RANGE_USED = 2'd3;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NONE    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

endpackage

>>> design/bpfa_map_mem.sv
// Frame usage map storage: one synchronous write port, one read port with
// registered read data. Depends on bpfa_pkg.
module bpfa_map_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [AW-1:0]                        rd_addr,
  output logic [bpfa_pkg::MAP_WORD_BITS-1:0]   rd_data,
  input  logic                                 wr_en,
  input  logic [AW-1:0]                        wr_addr,
  input  logic [bpfa_pkg::MAP_WORD_BITS-1:0]   wr_data
);

  logic [bpfa_pkg::MAP_WORD_BITS-1:0] mem [DEPTH];
  logic [bpfa_pkg::MAP_WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/bpfa_ctrl.sv
// Request sequencer: decodes transactions, scans and updates the usage map
// word by word, keeps free count and hint, holds the result register.
// Depends on bpfa_pkg; drives the ports of bpfa_map_mem.
module bpfa_ctrl #(
  parameter int FRAME_LIMIT = bpfa_pkg::FRAME_LIMIT_DEF,
  parameter int MAP_WORDS   = 2048,
  parameter int AW          = 11
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [1:0]                           in_mode,
  input  logic [bpfa_pkg::ADDR_W-1:0]          in_address,
  input  logic [bpfa_pkg::ADDR_W-1:0]          in_range_length,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [1:0]                           out_status,
  output logic [bpfa_pkg::ADDR_W-1:0]          out_page_address,
  output logic [bpfa_pkg::FRAME_W-1:0]         out_free_cnt,
  input  logic                                 cfg_we,
  input  logic [bpfa_pkg::FRAME_W-1:0]         cfg_wdata,
  output logic                                 mem_rd_en,
  output logic [AW-1:0]                        mem_rd_addr,
  input  logic [bpfa_pkg::MAP_WORD_BITS-1:0]   mem_rd_data,
  output logic                                 mem_wr_en,
  output logic [AW-1:0]                        mem_wr_addr,
  output logic [bpfa_pkg::MAP_WORD_BITS-1:0]   mem_wr_data
);

  localparam int W   = bpfa_pkg::MAP_WORD_BITS;
  localparam int WB  = bpfa_pkg::WORD_BIT_W;
  localparam int PB  = bpfa_pkg::PAGE_SHIFT;
  localparam int FW  = bpfa_pkg::FRAME_W;
  localparam int AD  = bpfa_pkg::ADDR_W;
  localparam int PFW = AD - PB;
  localparam logic [AD-1:0] PMASK = AD'(bpfa_pkg::PAGE_BYTES - 1);
  localparam logic [31:0]   MAX32 = 32'(FRAME_LIMIT);
  localparam logic [AW-1:0] LAST_MAP_WORD = AW'(MAP_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DEC, S_RSET, S_ACHK, S_FCHK, S_RWR, S_EMIT
  } state_t;

  function automatic logic [FW-1:0] clamp_total(input logic [FW-1:0] v);
    return (32'(v) > MAX32) ? MAX32[FW-1:0] : v;
  endfunction

  function automatic logic [WB:0] popcnt(input logic [W-1:0] v);
    logic [WB:0] c;
    c = '0;
    for (int i = 0; i < W; i++) begin
      c = c + (WB+1)'(v[i]);
    end
    return c;
  endfunction

  state_t               state_r;
  logic [1:0]           mode_r;
  logic [AD-1:0]        addr_r;
  logic [AD-1:0]        len_r;
  logic [AD-1:0]        end_r;
  logic [FW-1:0]        total_r;
  logic [FW-1:0]        count_r;
  logic [FW-1:0]        hint_r;
  logic [AW-1:0]        cur_w_r;
  logic [AW-1:0]        sw_r;
  logic [WB-1:0]        sb_r;
  logic                 first_r;
  logic                 wrap_r;
  logic [FW-1:0]        lo_r;
  logic [FW-1:0]        hi_r;
  logic [AW-1:0]        clr_w_r;
  bpfa_pkg::status_t    res_status_r;
  logic [AD-1:0]        res_page_r;
  logic                 out_tvalid_r;
  bpfa_pkg::status_t    out_status_r;
  logic [AD-1:0]        out_page_r;
  logic [FW-1:0]        out_free_r;

  logic [FW-1:0]        last_f;
  logic [AW-1:0]        last_w;
  logic [WB-1:0]        last_b;
  logic [FW-1:0]        start_f;
  logic [PFW-1:0]       pf;
  logic                 free_ok;
  logic [AD-1:0]        start_a;
  logic [AD-1:0]        end_calc;
  logic [PFW-1:0]       fs;
  logic [PFW-1:0]       fe;
  logic [FW-1:0]        fe_c;
  logic                 r_ign;
  logic                 r_none;

  logic [W-1:0]         a_mask;
  logic [W-1:0]         a_free;
  logic                 a_found;
  logic [WB-1:0]        a_idx;
  logic [FW-1:0]        a_frame;
  logic                 a_end;
  logic [AW-1:0]        a_next_w;

  logic [WB-1:0]        f_b;
  logic                 f_used;

  logic [AW-1:0]        lo_w;
  logic [AW-1:0]        hi_w;
  logic [WB-1:0]        lo_b;
  logic [WB-1:0]        hi_b;
  logic [W-1:0]         r_mask;
  logic [W-1:0]         r_new;
  logic [W-1:0]         r_chg;
  logic [WB:0]          r_pc;
  logic                 out_free_slot;

  assign last_f   = total_r - FW'(1);
  assign last_w   = last_f[WB +: AW];
  assign last_b   = last_f[WB-1:0];
  assign start_f  = (hint_r >= total_r) ? '0 : hint_r;
  assign pf       = addr_r[AD-1:PB];
  assign free_ok  = (addr_r != '0) && (32'(pf) < 32'(total_r));
  assign start_a  = addr_r & ~PMASK;
  assign end_calc = (addr_r + len_r + PMASK) & ~PMASK;
  assign fs       = start_a[AD-1:PB];
  assign fe       = end_r[AD-1:PB];
  assign fe_c     = (32'(fe) > 32'(total_r)) ? total_r : fe[FW-1:0];
  assign r_ign    = (len_r == '0) || (end_r <= start_a);
  assign r_none   = 32'(fs) >= 32'(fe_c);

  always_comb begin
    for (int i = 0; i < W; i++) begin
      a_mask[i] = ((cur_w_r != last_w) || (WB'(i) <= last_b)) &&
                  (!first_r || (WB'(i) >= sb_r));
    end
    a_free  = ~mem_rd_data & a_mask;
    a_found = |a_free;
    a_idx   = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (a_free[i]) begin
        a_idx = WB'(i);
      end
    end
  end

  assign a_frame  = FW'({cur_w_r, a_idx});
  assign a_end    = wrap_r && (cur_w_r == sw_r);
  assign a_next_w = (cur_w_r == last_w) ? '0 : cur_w_r + AW'(1);

  assign f_b    = lo_r[WB-1:0];
  assign f_used = mem_rd_data[f_b];

  assign lo_w = lo_r[WB +: AW];
  assign hi_w = hi_r[WB +: AW];
  assign lo_b = lo_r[WB-1:0];
  assign hi_b = hi_r[WB-1:0];

  always_comb begin
    for (int i = 0; i < W; i++) begin
      r_mask[i] = ((cur_w_r != lo_w) || (WB'(i) >= lo_b)) &&
                  ((cur_w_r != hi_w) || (WB'(i) <= hi_b));
    end
    if (mode_r == bpfa_pkg::MODE_RANGE_USED) begin
      r_new = mem_rd_data | r_mask;
      r_chg = r_mask & ~mem_rd_data;
    end else begin
      r_new = mem_rd_data & ~r_mask;
      r_chg = r_mask & mem_rd_data;
    end
  end

  assign r_pc = popcnt(r_chg);

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = cur_w_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = cur_w_r;
    mem_wr_data = r_new;
    case (state_r)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_w_r;
        mem_wr_data = '0;
      end
      S_DEC: begin
        if (mode_r == bpfa_pkg::MODE_ALLOC) begin
          mem_rd_en   = (total_r != '0);
          mem_rd_addr = start_f[WB +: AW];
        end else if (mode_r == bpfa_pkg::MODE_FREE) begin
          mem_rd_en   = free_ok;
          mem_rd_addr = pf[WB +: AW];
        end
      end
      S_RSET: begin
        mem_rd_en   = !r_ign && !r_none;
        mem_rd_addr = fs[WB +: AW];
      end
      S_ACHK: begin
        if (a_found) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = mem_rd_data | (W'(1) << a_idx);
        end else if (!a_end) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = a_next_w;
        end
      end
      S_FCHK: begin
        mem_wr_en   = f_used;
        mem_wr_addr = lo_w;
        mem_wr_data = mem_rd_data & ~(W'(1) << f_b);
      end
      S_RWR: begin
        mem_wr_en   = 1'b1;
        mem_rd_en   = (cur_w_r != hi_w);
        mem_rd_addr = cur_w_r + AW'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_free_slot = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_w_r      <= '0;
      total_r      <= clamp_total(FW'(bpfa_pkg::TOTAL_RESET));
      count_r      <= clamp_total(FW'(bpfa_pkg::TOTAL_RESET));
      hint_r       <= '0;
      out_tvalid_r <= 1'b0;
      first_r      <= 1'b0;
      wrap_r       <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (cfg_we || (state_r != S_EMIT))) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        total_r <= clamp_total(cfg_wdata);
        count_r <= clamp_total(cfg_wdata);
        hint_r  <= '0;
        clr_w_r <= '0;
        state_r <= S_CLEAR;
      end else begin
        case (state_r)
          S_CLEAR: begin
            clr_w_r <= clr_w_r + AW'(1);
            if (clr_w_r == LAST_MAP_WORD) begin
              state_r <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_tvalid) begin
              mode_r  <= in_mode;
              addr_r  <= in_address;
              len_r   <= in_range_length;
              state_r <= S_DEC;
            end
          end
          S_DEC: begin
            res_page_r <= '0;
            case (mode_r)
              bpfa_pkg::MODE_ALLOC: begin
                cur_w_r <= start_f[WB +: AW];
                sw_r    <= start_f[WB +: AW];
                sb_r    <= start_f[WB-1:0];
                first_r <= 1'b1;
                wrap_r  <= 1'b0;
                if (total_r == '0) begin
                  res_status_r <= bpfa_pkg::ST_NONE;
                  state_r      <= S_EMIT;
                end else begin
                  state_r <= S_ACHK;
                end
              end
              bpfa_pkg::MODE_FREE: begin
                lo_r <= pf[FW-1:0];
                if (free_ok) begin
                  state_r <= S_FCHK;
                end else begin
                  res_status_r <= bpfa_pkg::ST_IGNORED;
                  state_r      <= S_EMIT;
                end
              end
              default: begin
                end_r   <= end_calc;
                state_r <= S_RSET;
              end
            endcase
          end
          S_RSET: begin
            lo_r    <= fs[FW-1:0];
            hi_r    <= fe_c - FW'(1);
            cur_w_r <= fs[WB +: AW];
            if (r_ign) begin
              res_status_r <= bpfa_pkg::ST_IGNORED;
              state_r      <= S_EMIT;
            end else if (r_none) begin
              res_status_r <= bpfa_pkg::ST_DONE;
              state_r      <= S_EMIT;
            end else begin
              state_r <= S_RWR;
            end
          end
          S_ACHK: begin
            if (a_found) begin
              count_r      <= count_r - FW'(1);
              hint_r       <= a_frame + FW'(1);
              res_page_r   <= AD'({a_frame, {PB{1'b0}}});
              res_status_r <= bpfa_pkg::ST_DONE;
              state_r      <= S_EMIT;
            end else if (a_end) begin
              res_status_r <= bpfa_pkg::ST_NONE;
              state_r      <= S_EMIT;
            end else begin
              cur_w_r <= a_next_w;
              first_r <= 1'b0;
              wrap_r  <= wrap_r || (cur_w_r == last_w);
            end
          end
          S_FCHK: begin
            if (f_used) begin
              count_r      <= count_r + FW'(1);
              res_status_r <= bpfa_pkg::ST_DONE;
              if ((lo_r < hint_r) || (hint_r == total_r)) begin
                hint_r <= lo_r;
              end
            end else begin
              res_status_r <= bpfa_pkg::ST_IGNORED;
            end
            state_r <= S_EMIT;
          end
          S_RWR: begin
            if (mode_r == bpfa_pkg::MODE_RANGE_USED) begin
              count_r <= count_r - FW'(r_pc);
            end else begin
              count_r <= count_r + FW'(r_pc);
            end
            cur_w_r <= cur_w_r + AW'(1);
            if (cur_w_r == hi_w) begin
              res_status_r <= bpfa_pkg::ST_DONE;
              state_r      <= S_EMIT;
            end
          end
          S_EMIT: begin
            if (out_free_slot) begin
              out_tvalid_r <= 1'b1;
              out_status_r <= res_status_r;
              out_page_r   <= res_page_r;
              out_free_r   <= count_r;
              state_r      <= S_IDLE;
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign in_tready        = (state_r == S_IDLE);
  assign out_tvalid       = out_tvalid_r;
  assign out_status       = out_status_r;
  assign out_page_address = out_page_r;
  assign out_free_cnt     = out_free_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= total_r)
    else $error("free count above managed frames");

  a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hint_r <= total_r)
    else $error("hint beyond managed frames");

  a_wr_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && (state_r != S_CLEAR)) |-> (mem_wr_addr <= last_w))
    else $error("map write beyond last managed word");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit");

endmodule

>>> design/bitmap_page_frame_allocator.sv
// Next-fit bitmap page frame allocator over bpfa_ctrl and bpfa_map_mem (bpfa_pkg).
// Result registered after acceptance and after any map scan or update (an allocation scans
// at most map words + 1 words); an output stall can hold it further.
// One transaction in flight: the next is accepted the cycle after the result is registered.
// Reset and every frame-total write start a clearing pass over every map word
// (2048 at default size); no transaction is accepted meanwhile.
module bitmap_page_frame_allocator #(
  parameter int FRAME_LIMIT = bpfa_pkg::FRAME_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[1:0], address[33:2], range_length[65:34], zero pad [71:66]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], page_address[33:2], free count[50:34], zero pad [55:51]
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  localparam int EFF_FRAMES = (FRAME_LIMIT > bpfa_pkg::TOTAL_MAX) ?
                              bpfa_pkg::TOTAL_MAX : FRAME_LIMIT;
  localparam int MAP_WORDS  = (EFF_FRAMES + bpfa_pkg::MAP_WORD_BITS - 1) /
                              bpfa_pkg::MAP_WORD_BITS;
  localparam int AW         = $clog2(MAP_WORDS);

  logic                                mem_rd_en;
  logic [AW-1:0]                       mem_rd_addr;
  logic [bpfa_pkg::MAP_WORD_BITS-1:0]  mem_rd_data;
  logic                                mem_wr_en;
  logic [AW-1:0]                       mem_wr_addr;
  logic [bpfa_pkg::MAP_WORD_BITS-1:0]  mem_wr_data;
  logic [1:0]                          out_status;
  logic [31:0]                         out_page_address;
  logic [16:0]                         out_free_cnt;

  bpfa_ctrl #(
    .FRAME_LIMIT (FRAME_LIMIT),
    .MAP_WORDS   (MAP_WORDS),
    .AW          (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_mode          (in_tdata[1:0]),
    .in_address       (in_tdata[33:2]),
    .in_range_length  (in_tdata[65:34]),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_status       (out_status),
    .out_page_address (out_page_address),
    .out_free_cnt     (out_free_cnt),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .mem_rd_en        (mem_rd_en),
    .mem_rd_addr      (mem_rd_addr),
    .mem_rd_data      (mem_rd_data),
    .mem_wr_en        (mem_wr_en),
    .mem_wr_addr      (mem_wr_addr),
    .mem_wr_data      (mem_wr_data)
  );

  bpfa_map_mem #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign out_tdata = {5'd0, out_free_cnt, out_page_address, out_status};

endmodule
